[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

[rtl/pmt_pkg.sv]
// ----------------------------------------------------------------------------
// pmt_pkg
// Types and constants of the per-channel average and peak tracker.
// ----------------------------------------------------------------------------
package pmt_pkg;

  localparam int CHAN_W      = 4;
  localparam int SMP_W       = 25;
  localparam int CNT_W       = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [SMP_W-1:0] smp_t;

  // peak reset values: range extremes of a 25-bit signed sample
  localparam smp_t PEAK_MIN = {1'b1, {(SMP_W-1){1'b0}}};
  localparam smp_t PEAK_MAX = {1'b0, {(SMP_W-1){1'b1}}};

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t               op;
    logic              ok;
    logic [CHAN_W-1:0] chan;
    smp_t              sample;
  } cmd_t;

  // result word
  typedef struct packed {
    logic             dropped;
    logic [CNT_W-1:0] seen;
    smp_t             low;
    smp_t             high;
    smp_t             avg;
  } res_t;

endpackage

[rtl/per_channel_iir_min_max_tracker_unit.sv]
// Path: a result word reaches m_tvalid through the input hold register, the
// command queue and the output register after its input word is accepted.
// Throughput: one word per cycle sustained while m_tready stays high; each
// channel update is a combinational read-modify-write of flip-flop stores.
// Reset: synchronous rst clears averages to zero, peaks to the range extremes,
// the sample counter to zero, and empties the input register, queue and output.
// ----------------------------------------------------------------------------
// per_channel_iir_min_max_tracker_unit
// Per-channel half-step IIR average with running max/min, and one sample counter.
// ----------------------------------------------------------------------------
module per_channel_iir_min_max_tracker_unit
  import pmt_pkg::*;
#(
  parameter int NUM_CHANNELS = 16
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // channel[3:0], sample[28:4], zero[31:29]
  input  logic         s_tuser,   // op[0]
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // average[24:0], peak_high[49:25],
                                  // peak_low[74:50], samples_seen[106:75],
                                  // zero[111:107]
  output logic         m_tuser    // dropped[0]
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;
  res_t out_res;
  op_t  in_op;

  assign in_op = op_t'(s_tuser);

  // front: capture and classify
  pmt_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (in_op),
    .in_chan  (s_tdata[CHAN_W-1:0]),
    .in_sample(smp_t'(s_tdata[CHAN_W+SMP_W-1:CHAN_W])),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // command queue
  pmt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  // back: channel update and output register
  pmt_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (out_res)
  );

  // pack the result word
  assign m_tdata = {5'b0, out_res.seen, out_res.low, out_res.high, out_res.avg};
  assign m_tuser = out_res.dropped;

endmodule

[rtl/pmt_queue.sv]
// ----------------------------------------------------------------------------
// pmt_queue
// Small FIFO between the classifying front and the update back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmt_queue
  import pmt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(QUEUE_DEPTH);

  cmd_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign full    = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_push_when_full, clk, rst, push && full)
  `ASSERT_NEVER(a_pop_when_empty, clk, rst, pop && !q_valid)

endmodule

[rtl/pmt_front.sv]
// ----------------------------------------------------------------------------
// pmt_front
// Input stage: registers an incoming word, checks the channel range and
// hands the classified command to the queue.
// ----------------------------------------------------------------------------
module pmt_front
  import pmt_pkg::*;
#(
  parameter int NUM_CHANNELS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  op_t               in_op,
  input  logic [CHAN_W-1:0] in_chan,
  input  smp_t              in_sample,
  input  logic              q_full,
  output logic              push,
  output cmd_t              push_cmd
);

  localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W+1)'(NUM_CHANNELS);

  logic hold_valid;
  cmd_t hold_cmd;
  logic take;

  assign push     = hold_valid && !q_full;
  assign push_cmd = hold_cmd;
  assign in_ready = !hold_valid || push;
  assign take     = in_valid && in_ready;

  // hold register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  // classify and capture the word
  always_ff @(posedge clk) begin
    if (take) begin
      hold_cmd.op     <= in_op;
      hold_cmd.ok     <= ({1'b0, in_chan} < CH_LIMIT);
      hold_cmd.chan   <= in_chan;
      hold_cmd.sample <= in_sample;
    end
  end

endmodule

[rtl/pmt_back.sv]
// ----------------------------------------------------------------------------
// pmt_back
// Update stage: read-modify-write of the channel average and peaks, the
// sample counter, and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmt_back
  import pmt_pkg::*;
#(
  parameter int NUM_CHANNELS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  smp_t             avg_store  [NUM_CHANNELS];
  smp_t             high_store [NUM_CHANNELS];
  smp_t             low_store  [NUM_CHANNELS];
  logic [CNT_W-1:0] counter;

  logic [IDX_W-1:0]  idx;
  smp_t              cur_avg;
  smp_t              cur_high;
  smp_t              cur_low;
  logic signed [SMP_W:0] sum;
  smp_t              avg_next;
  smp_t              high_next;
  smp_t              low_next;
  logic [CNT_W-1:0]  counter_next;
  logic              wr_en;
  res_t              res_next;

  assign pop = q_valid && (!out_valid || out_ready);
  assign idx = q_cmd.chan[IDX_W-1:0];

  assign cur_avg  = avg_store[idx];
  assign cur_high = high_store[idx];
  assign cur_low  = low_store[idx];

  // sign-extended sum; bits [SMP_W:1] give the floor of the half sum
  assign sum = {cur_avg[SMP_W-1], cur_avg} + {q_cmd.sample[SMP_W-1], q_cmd.sample};

  // new channel state and counter
  always_comb begin
    avg_next     = cur_avg;
    high_next    = cur_high;
    low_next     = cur_low;
    counter_next = counter;
    wr_en        = 1'b0;
    unique case (q_cmd.op)
      OP_SAMPLE: begin
        if (q_cmd.ok) begin
          wr_en        = 1'b1;
          avg_next     = sum[SMP_W:1];
          high_next    = (q_cmd.sample > cur_high) ? q_cmd.sample : cur_high;
          low_next     = (q_cmd.sample < cur_low) ? q_cmd.sample : cur_low;
          counter_next = counter + 1'b1;
        end
      end
      OP_CLEAR: begin
        counter_next = '0;
        if (q_cmd.ok) begin
          wr_en     = 1'b1;
          high_next = PEAK_MIN;
          low_next  = PEAK_MAX;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // result word
  always_comb begin
    res_next.seen = counter_next;
    if (q_cmd.ok) begin
      res_next.dropped = 1'b0;
      res_next.avg     = avg_next;
      res_next.high    = high_next;
      res_next.low     = low_next;
    end else begin
      res_next.dropped = 1'b1;
      res_next.avg     = '0;
      res_next.high    = '0;
      res_next.low     = '0;
    end
  end

  // channel stores and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        avg_store[i]  <= '0;
        high_store[i] <= PEAK_MIN;
        low_store[i]  <= PEAK_MAX;
      end
      counter <= '0;
    end else if (pop) begin
      if (wr_en) begin
        avg_store[idx]  <= avg_next;
        high_store[idx] <= high_next;
        low_store[idx]  <= low_next;
      end
      counter <= counter_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= res_next;
    end
  end

  `ASSERT_PROP(a_clear_zeroes_count, clk, rst,
    (pop && q_cmd.op == OP_CLEAR) |=> (out_valid && out_res.seen == '0))
  `ASSERT_PROP(a_sample_counts, clk, rst,
    (pop && q_cmd.op == OP_SAMPLE && q_cmd.ok) |=> (counter == $past(counter) + 1'b1))

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the tracker with directed and random sample/clear words under
// random back-pressure. A scoreboard predicts the average, peaks, sample
// count and drop flag of each word and compares them with the result stream.
// ----------------------------------------------------------------------------
module testbench;
  import pmt_pkg::*;

  // full channel count of the id field
  localparam int NUM_CH     = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_WORDS = 630;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [31:0]  s_tdata;   // channel[3:0], sample[28:4], zero[31:29]
  logic         s_tuser;   // op[0]
  logic         m_tvalid;
  logic         m_tready;
  logic [111:0] m_tdata;   // average[24:0], peak_high[49:25], peak_low[74:50],
                           // samples_seen[106:75], zero[111:107]
  logic         m_tuser;   // dropped[0]

  logic         fast_phase;
  int           idle_cycles;

  // per-channel stats predictor and queue of expected result words
  class iir_peak_scoreboard;
    smp_t             avg_mem [16];
    smp_t             high_mem[16];
    smp_t             low_mem [16];
    logic [CNT_W-1:0] seen_count;
    res_t             expected_stats[$];
    int               errors;

    function new();
      for (int i = 0; i < 16; i++) begin
        avg_mem[i]  = '0;
        high_mem[i] = PEAK_MIN;
        low_mem[i]  = PEAK_MAX;
      end
      seen_count = '0;
      errors     = 0;
    endfunction

    // update the channel state for an accepted word and queue its result
    function void note_word(op_t op, logic [CHAN_W-1:0] chan, smp_t smp);
      res_t                    r;
      logic signed [SMP_W:0]   total;
      logic                    ok;
      ok = (chan < NUM_CH);
      r  = '0;
      if (op == OP_CLEAR) begin
        seen_count = '0;
        if (ok) begin
          high_mem[chan] = PEAK_MIN;
          low_mem[chan]  = PEAK_MAX;
        end
      end else if (ok) begin
        // floor of the half sum: arithmetic shift of the 26-bit total
        total         = avg_mem[chan] + smp;
        avg_mem[chan] = total[SMP_W:1];
        if (smp > high_mem[chan]) high_mem[chan] = smp;
        if (smp < low_mem[chan]) low_mem[chan] = smp;
        seen_count = seen_count + 1;
      end
      if (ok) begin
        r.avg  = avg_mem[chan];
        r.high = high_mem[chan];
        r.low  = low_mem[chan];
      end
      r.dropped = !ok;
      r.seen    = seen_count;
      expected_stats.push_back(r);
    endfunction

    // compare one result word with the oldest expectation
    function void check_word(logic [111:0] data, logic dropped);
      res_t             r;
      smp_t             got_avg;
      smp_t             got_high;
      smp_t             got_low;
      logic [CNT_W-1:0] got_seen;
      if (expected_stats.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
        return;
      end
      r        = expected_stats.pop_front();
      got_avg  = smp_t'(data[24:0]);
      got_high = smp_t'(data[49:25]);
      got_low  = smp_t'(data[74:50]);
      got_seen = data[106:75];
      if (got_avg !== r.avg) begin
        $error("average: expected %0d actual %0d", r.avg, got_avg);
        errors++;
      end
      if (got_high !== r.high) begin
        $error("peak_high: expected %0d actual %0d", r.high, got_high);
        errors++;
      end
      if (got_low !== r.low) begin
        $error("peak_low: expected %0d actual %0d", r.low, got_low);
        errors++;
      end
      if (got_seen !== r.seen) begin
        $error("samples_seen: expected %0d actual %0d", r.seen, got_seen);
        errors++;
      end
      if (dropped !== r.dropped) begin
        $error("dropped: expected %0d actual %0d", r.dropped, dropped);
        errors++;
      end
      if (data[111:107] !== 5'd0) begin
        $error("padding: expected %0d actual %0d", 5'd0, data[111:107]);
        errors++;
      end
    endfunction
  endclass

  iir_peak_scoreboard sb;

  per_channel_iir_min_max_tracker_unit #(
    .NUM_CHANNELS(NUM_CH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idle length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // send one word, wait for the handshake, then maybe idle
  task automatic push_word(op_t op, logic [CHAN_W-1:0] chan, smp_t smp);
    int gap;
    s_tvalid = 1'b1;
    s_tdata  = {3'b000, smp, chan};
    s_tuser  = op;
    do @(posedge clk); while (!s_tready);
    sb.note_word(op, chan, smp);
    @(negedge clk);
    gap = 0;
    if (!fast_phase && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // hold off the sender until every expected result has come back
  task automatic drain_results();
    s_tvalid = 1'b0;
    while (sb.expected_stats.size() != 0) @(negedge clk);
  endtask

  // result side back-pressure
  initial begin
    m_tready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (!fast_phase && $urandom_range(0, 3) == 0) begin
        m_tready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
      m_tready = 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(negedge clk);
      else repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // result checking at the rising edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [CHAN_W-1:0] chan;
    smp_t              smp;
    op_t               op;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    fast_phase  = 1'b0;
    sb          = new();
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // range extremes on one channel, floor rounding of negative half sums
    push_word(OP_SAMPLE, 4'd0, PEAK_MAX);
    push_word(OP_SAMPLE, 4'd0, PEAK_MIN);
    push_word(OP_SAMPLE, 4'd0, PEAK_MIN);
    push_word(OP_SAMPLE, 4'd1, smp_t'(-1));
    push_word(OP_SAMPLE, 4'd1, smp_t'(1));
    push_word(OP_SAMPLE, 4'd1, smp_t'(-2));
    // clear keeps the average and ignores the sample field
    push_word(OP_CLEAR, 4'd0, PEAK_MAX);
    push_word(OP_SAMPLE, 4'd0, smp_t'(0));
    push_word(OP_SAMPLE, CHAN_W'(NUM_CH - 1), PEAK_MAX);
    push_word(OP_SAMPLE, CHAN_W'(NUM_CH - 1), PEAK_MAX);
    // highest channel id, clears on several channels zero the count
    push_word(OP_SAMPLE, 4'd15, smp_t'(5));
    push_word(OP_SAMPLE, 4'd15, PEAK_MIN);
    push_word(OP_SAMPLE, 4'd2, smp_t'(12345));
    push_word(OP_CLEAR, 4'd15, smp_t'(0));
    push_word(OP_SAMPLE, 4'd3, smp_t'(12345));
    push_word(OP_CLEAR, 4'd3, PEAK_MIN);
    push_word(OP_CLEAR, 4'd3, smp_t'(0));
    push_word(OP_SAMPLE, 4'd7, PEAK_MIN);
    push_word(OP_SAMPLE, 4'd7, PEAK_MAX);
    push_word(OP_SAMPLE, 4'd7, smp_t'(0));

    // random words, with a back-to-back stretch and a couple of drains
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == 200 || n == 450) drain_results();
      fast_phase = (n >= 200 && n < 300);
      op = ($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_SAMPLE;
      chan = CHAN_W'($urandom_range(0, NUM_CH - 1));
      case ($urandom_range(0, 9))
        0:       smp = PEAK_MAX;
        1:       smp = PEAK_MIN;
        2:       smp = smp_t'(int'($urandom_range(0, 64)) - 32);
        default: smp = smp_t'($urandom());
      endcase
      push_word(op, chan, smp);
    end
    fast_phase = 1'b0;

    // wait out the pipeline
    drain_results();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.expected_stats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
